// ===== design/sdalu_pkg.sv =====
package sdalu_pkg;

  localparam int MAX_POWER = 18;
  localparam int IN_W      = 144;
  localparam int OUT_W     = 80;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_CMP = 3'd2;
  localparam logic [2:0] KIND_MUL = 3'd3;
  localparam logic [2:0] KIND_DIV = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } d10_stat_t;

  typedef enum logic [1:0] {
    STRIP_A, STRIP_B, STRIP_R, STRIP_D
  } strip_id_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_START = 11'b00000000010,
    S_SCALE = 11'b00000000100,
    S_MUL   = 11'b00000001000,
    S_STRIP = 11'b00000010000,
    S_SWAIT = 11'b00000100000,
    S_SNEXT = 11'b00001000000,
    S_FIT   = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_DONE  = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_t;

  function automatic logic [4:0] clamp_places(logic [4:0] p);
    return (p > 5'(MAX_POWER)) ? 5'(MAX_POWER) : p;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

endpackage

// ===== design/sdalu_div10.sv =====
module sdalu_div10 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           value,
  output logic [63:0]           quot,
  output sdalu_pkg::d10_stat_t  stat
);
  import sdalu_pkg::*;

  logic        busy;
  logic        done;
  logic [2:0]  cnt;
  logic [63:0] n;
  logic [63:0] q;
  logic [3:0]  r;
  logic [7:0]  qbits;
  logic [3:0]  r_next;

  // eight bits of long division by ten per cycle
  always_comb begin
    logic [4:0] t;
    logic [3:0] rr;
    rr = r;
    qbits = '0;
    for (int i = 0; i < 8; i++) begin
      t = {rr, n[63 - i]};
      if (t >= 5'd10) begin
        qbits[7 - i] = 1'b1;
        rr = 4'(t - 5'd10);
      end else begin
        rr = t[3:0];
      end
    end
    r_next = rr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 3'd7);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= value;
      q   <= '0;
      r   <= '0;
      cnt <= '0;
    end else if (busy) begin
      n   <= {n[55:0], 8'd0};
      q   <= {q[55:0], qbits};
      r   <= r_next;
      cnt <= cnt + 3'd1;
    end
  end

  assign quot          = q;
  assign stat.done     = done;
  assign stat.rem_zero = (r == 4'd0);

endmodule

// ===== design/scaled_decimal_alu_unit.sv =====
// one item at a time: s_tready is high only while the sequencer is idle, from the result cycle on
// add, subtract, compare: operand with fewer places scaled by ten per place of the gap (up to 18)
// multiply: shift-add unit; if the product wraps, both operands are stripped of trailing zeros
// and multiplied again, else trailing zeros are stripped from the product by divide-by-ten trials
// divide: divisor stripped by divide-by-ten trials, up to 18 scale and 18 fit steps, 64 restoring steps
// rst clears the sequencer and the output valid; there is no clearing pass
module scaled_decimal_alu_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // a_value, a_places, b_value, b_decimals, quotient_places, zero pad
  input  logic [sdalu_pkg::IN_W-1:0]    s_tdata,
  // kind
  input  logic [2:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // result_value, result_places, order, status, zero pad
  output logic [sdalu_pkg::OUT_W-1:0]   m_tdata
);
  import sdalu_pkg::*;

  state_t      state;
  logic [2:0]  kind_r;
  logic [63:0] a;
  logic [63:0] b;
  logic [4:0]  ap;
  logic [4:0]  bp;
  logic [4:0]  qp;
  logic [127:0] acc;
  logic [6:0]  cnt;
  logic [63:0] mc;
  logic [63:0] sv;
  logic [5:0]  sp;
  strip_id_t   sid;
  logic        ascl;
  logic        sgn;
  logic        mphase;
  logic [5:0]  pa;
  logic [5:0]  pb;
  logic        bneg;
  logic        bz;
  logic        qneg;
  logic [4:0]  pw;
  logic [4:0]  pl;
  logic [63:0] rv;
  logic [5:0]  rp;
  logic [1:0]  ord;
  logic [1:0]  st;
  logic [OUT_W-1:0] out_data;

  logic [127:0] acc10;
  logic [64:0]  msum;
  logic [64:0]  trial;
  logic [127:0] av;
  logic [127:0] bv;
  logic [63:0]  lim;
  logic [6:0]   pw_u;
  logic [6:0]   excess;
  logic [4:0]   dec;
  logic [63:0]  bval;
  logic         d10_start;
  logic [63:0]  d10_quot;
  d10_stat_t    d10_stat;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_data;

  // shared datapath pieces
  assign acc10  = {acc[124:0], 3'd0} + {acc[126:0], 1'b0};
  assign msum   = {1'b0, acc[127:64]} + (acc[0] ? {1'b0, mc} : 65'd0);
  assign trial  = {1'b0, acc[126:63]} - {1'b0, mc};
  assign av     = ascl ? acc : {{64{a[63]}}, a};
  assign bv     = ascl ? {{64{b[63]}}, b} : acc;
  assign lim    = sgn ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  assign bval   = bneg ? (64'd0 - sv) : sv;
  assign pw_u   = {2'b0, qp} + {1'b0, sp} - {2'b0, ap};
  assign excess = pw_u - 7'(MAX_POWER);
  assign dec    = pw - cnt[4:0];

  assign d10_start = (state == S_STRIP) && (sp != 6'd0);

  sdalu_div10 u_div10 (
    .clk   (clk),
    .rst   (rst),
    .start (d10_start),
    .value (sv),
    .quot  (d10_quot),
    .stat  (d10_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_START;
          end
        end
        S_START: begin
          case (kind_r)
            KIND_ADD, KIND_SUB, KIND_CMP: state <= S_SCALE;
            KIND_MUL: state <= S_MUL;
            KIND_DIV: state <= (b == 64'd0) ? S_DONE : S_STRIP;
            default: state <= S_DONE;
          endcase
        end
        S_SCALE: begin
          if (cnt == 7'd0) begin
            state <= (kind_r == KIND_DIV) ? S_FIT : S_DONE;
          end
        end
        S_MUL: begin
          if (cnt == 7'd0) begin
            state <= mphase ? S_DONE : S_STRIP;
          end
        end
        S_STRIP: begin
          state <= (sp == 6'd0) ? S_SNEXT : S_SWAIT;
        end
        S_SWAIT: begin
          if (d10_stat.done) begin
            state <= d10_stat.rem_zero ? S_STRIP : S_SNEXT;
          end
        end
        S_SNEXT: begin
          case (sid)
            STRIP_A: state <= S_STRIP;
            STRIP_B: state <= S_MUL;
            STRIP_R: state <= S_DONE;
            default: begin
              if (!pw_u[6] && pw_u > 7'(MAX_POWER) && excess[4:0] > qp) begin
                state <= S_DONE;
              end else begin
                state <= S_SCALE;
              end
            end
          endcase
        end
        S_FIT: begin
          if (!({2'b0, pw} > cnt && acc10[127:63] == 65'd0)) begin
            state <= (dec > pl || bz) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 7'd0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind_r <= s_tuser;
        a      <= s_tdata[63:0];
        ap     <= clamp_places(s_tdata[68:64]);
        b      <= s_tdata[132:69];
        bp     <= clamp_places(s_tdata[137:133]);
        qp     <= clamp_places(s_tdata[142:138]);
      end
      S_START: begin
        rv  <= '0;
        rp  <= '0;
        ord <= ORD_EQ;
        st  <= ST_OK;
        case (kind_r)
          KIND_ADD, KIND_SUB, KIND_CMP: begin
            ascl <= (bp > ap);
            if (bp > ap) begin
              acc <= {{64{a[63]}}, a};
              cnt <= {2'b0, bp - ap};
            end else begin
              acc <= {{64{b[63]}}, b};
              cnt <= {2'b0, ap - bp};
            end
          end
          KIND_MUL: begin
            sgn    <= a[63] ^ b[63];
            mc     <= mag64(a);
            acc    <= {64'd0, mag64(b)};
            cnt    <= 7'd64;
            mphase <= 1'b0;
          end
          KIND_DIV: begin
            rv   <= a;
            rp   <= {1'b0, ap};
            bneg <= b[63];
            sv   <= mag64(b);
            sp   <= {1'b0, bp};
            sid  <= STRIP_D;
            if (b == 64'd0) begin
              st <= ST_ZERO;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCALE: begin
        if (cnt != 7'd0) begin
          acc <= acc10;
          cnt <= cnt - 7'd1;
        end else if (kind_r == KIND_DIV) begin
          mc   <= mag64(acc[63:0]);
          bneg <= acc[63];
          bz   <= (acc[63:0] == 64'd0);
          acc  <= {64'd0, mag64(a)};
        end else begin
          case (kind_r)
            KIND_ADD: begin
              rv <= av[63:0] + bv[63:0];
              rp <= {1'b0, ascl ? bp : ap};
            end
            KIND_SUB: begin
              rv <= av[63:0] - bv[63:0];
              rp <= {1'b0, ascl ? bp : ap};
            end
            default: begin
              if ($signed(av) < $signed(bv)) begin
                ord <= ORD_LT;
              end else if ($signed(av) > $signed(bv)) begin
                ord <= ORD_GT;
              end else begin
                ord <= ORD_EQ;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        if (cnt != 7'd0) begin
          acc <= {msum, acc[63:1]};
          cnt <= cnt - 7'd1;
        end else if (mphase) begin
          rv <= sgn ? (64'd0 - acc[63:0]) : acc[63:0];
          rp <= pa + pb;
        end else if (acc > {64'd0, lim}) begin
          // wrapped: strip both operands and multiply again
          sv  <= mag64(a);
          sp  <= {1'b0, ap};
          sid <= STRIP_A;
        end else begin
          sv  <= acc[63:0];
          sp  <= {1'b0, ap} + {1'b0, bp};
          sid <= STRIP_R;
        end
      end
      S_SWAIT: begin
        if (d10_stat.done && d10_stat.rem_zero) begin
          sv <= d10_quot;
          sp <= sp - 6'd1;
        end
      end
      S_SNEXT: begin
        case (sid)
          STRIP_A: begin
            mc  <= sv;
            pa  <= sp;
            sv  <= mag64(b);
            sp  <= {1'b0, bp};
            sid <= STRIP_B;
          end
          STRIP_B: begin
            pb     <= sp;
            acc    <= {64'd0, sv};
            cnt    <= 7'd64;
            mphase <= 1'b1;
          end
          STRIP_R: begin
            rv <= sgn ? (64'd0 - sv) : sv;
            rp <= sp;
          end
          default: begin
            acc <= {{64{bval[63]}}, bval};
            if (pw_u[6]) begin
              cnt <= 7'd0 - pw_u;
              pw  <= '0;
              pl  <= qp;
            end else if (pw_u > 7'(MAX_POWER)) begin
              cnt <= '0;
              pw  <= 5'(MAX_POWER);
              pl  <= qp - excess[4:0];
              if (excess[4:0] > qp) begin
                st <= ST_OVF;
              end
            end else begin
              cnt <= '0;
              pw  <= pw_u[4:0];
              pl  <= qp;
            end
          end
        endcase
      end
      S_FIT: begin
        // largest power not above pw that keeps the scaled dividend in range
        if ({2'b0, pw} > cnt && acc10[127:63] == 65'd0) begin
          acc <= acc10;
          cnt <= cnt + 7'd1;
        end else if (dec > pl) begin
          st <= ST_OVF;
        end else if (bz) begin
          st <= ST_ZERO;
        end else begin
          pl   <= pl - dec;
          acc  <= {64'd0, acc[63:0]};
          cnt  <= 7'd64;
          qneg <= a[63] ^ bneg;
        end
      end
      S_DIV: begin
        if (cnt != 7'd0) begin
          if (!trial[64]) begin
            acc <= {trial[63:0], acc[62:0], 1'b1};
          end else begin
            acc <= {acc[126:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
        end else begin
          rv <= qneg ? (64'd0 - acc[63:0]) : acc[63:0];
          rp <= {1'b0, pl};
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_data <= {6'd0, st, ord, rp, rv};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_d10_wait: assert property (@(posedge clk) disable iff (rst)
    d10_stat.done |-> state == S_SWAIT)
    else $error("divide-by-ten result outside strip wait");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == S_START)
    else $error("accepted item did not start");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_tvalid && !m_tready) |=> state == S_DONE)
    else $error("result dropped while output stalled");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DIV) |-> cnt <= 7'd64)
    else $error("serial step count out of range");
`endif

endmodule
